>>> rtl/core/sic_pkg.sv
// package for the significant inversion counter
// shared widths, limits and the token that runs down the cell chain
`default_nettype none

package sic_pkg;

    localparam int SIC_MAX_ITEMS = 256;
    localparam int VALUE_W       = 30;
    localparam int TRIPLE_W      = 32;
    localparam int TOTAL_W       = 15;
    localparam int SUM_W         = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // one item as it travels from cell to cell
    typedef struct packed {
        logic                vld;
        logic                last;
        logic                stored;
        logic [VALUE_W-1:0]  value;
        logic [TRIPLE_W-1:0] triple;
    } t_sic_tok;

endpackage

`default_nettype wire

>>> rtl/core/sic_in_if.sv
// input channel: valid/ready handshake with one sequence element per beat
// depends on sic_pkg for the value width
`default_nettype none

interface sic_in_if;
    import sic_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sic_out_if.sv
// result channel: valid/ready handshake with one running total per beat
// depends on sic_pkg for the total width
`default_nettype none

interface sic_out_if;
    import sic_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] running_total;
    logic               end_of_sequence;
    logic               overflow;

    modport source (output valid, output running_total, output end_of_sequence,
                    output overflow, input ready);
    modport sink   (input valid, input running_total, input end_of_sequence,
                    input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/significant_inversion_counter.sv
// top level of the significant inversion counter
// depends on sic_pkg, sic_in_if, sic_out_if, sic_cell and sic_tail
//
// usage:
//   i_in carries one sequence element per beat (value, last); o_out returns one
//   beat per input beat with the running count of earlier elements greater
//   than three times the current one, the last flag and the overflow flag.
//   items run down a row of MAX_ITEMS compare cells, one cell per cycle unless
//   o_out stalls; each cell holds one stored value and the first empty cell
//   keeps the item. an item passes one register per cell and then the output
//   register. throughput: one item per cycle unless o_out stalls; items of
//   the next sequence may follow the closing item directly; the cell row
//   length sets the latency only.
//   a closing item empties every cell it passes and clears the total after
//   its own result. an item that finds every cell full is dropped, the total
//   saturates and overflow stays set until the end of that sequence.
//   reset empties all cells and the total; stored values are not cleared.
//   when o_out stalls, the output register holds and the whole row freezes,
//   so i_in.ready drops in the same cycle.
`default_nettype none

module significant_inversion_counter
    import sic_pkg::*;
#(
    parameter int MAX_ITEMS = SIC_MAX_ITEMS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sic_in_if.sink    i_in,
    sic_out_if.source o_out
);

    localparam int HIT_W = $clog2(MAX_ITEMS + 1);

    t_sic_tok         tok  [0:MAX_ITEMS];
    logic [HIT_W-1:0] hits [0:MAX_ITEMS];
    logic             adv;

    assign i_in.ready = adv;

    always_comb begin
        tok[0].vld    = i_in.valid;
        tok[0].last   = i_in.last;
        tok[0].stored = 1'b0;
        tok[0].value  = i_in.value;
        // three times the value, formed wide so it never wraps
        tok[0].triple = {2'b00, i_in.value} + {1'b0, i_in.value, 1'b0};
        hits[0]       = '0;
    end

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        sic_cell #(
            .HIT_W (HIT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok[g]),
            .i_hits  (hits[g]),
            .o_tok   (tok[g+1]),
            .o_hits  (hits[g+1])
        );
    end

    sic_tail #(
        .HIT_W (HIT_W)
    ) u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok[MAX_ITEMS]),
        .i_hits  (hits[MAX_ITEMS]),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/sic_cell.sv
// one compare cell: holds one earlier value, counts hits of passing items
// and stores the first item that finds it empty; depends on sic_pkg
`default_nettype none

module sic_cell
    import sic_pkg::*;
#(
    parameter int HIT_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire t_sic_tok         i_tok,
    input  wire logic [HIT_W-1:0] i_hits,
    output t_sic_tok              o_tok,
    output logic      [HIT_W-1:0] o_hits
);

    logic               r_full;
    logic [VALUE_W-1:0] r_data;
    t_sic_tok           r_tok;
    logic [HIT_W-1:0]   r_hits;

    logic               n_full;
    t_sic_tok           n_tok;
    logic [HIT_W-1:0]   n_hits;
    logic               hit;
    logic               take;

    always_comb begin
        hit  = i_tok.vld && r_full &&
               ({{(TRIPLE_W-VALUE_W){1'b0}}, r_data} > i_tok.triple);
        take = i_tok.vld && !i_tok.stored && !r_full;

        n_hits = i_hits + {{(HIT_W-1){1'b0}}, hit};

        n_tok        = i_tok;
        n_tok.stored = i_tok.stored || take;

        // the closing item empties the cell once it has been compared
        n_full = r_full;
        if (i_tok.vld && i_tok.last) begin
            n_full = 1'b0;
        end else if (take) begin
            n_full = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_full <= n_full;
            r_tok  <= n_tok;
            r_hits <= n_hits;
            if (take) begin
                r_data <= i_tok.value;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_hits = r_hits;

endmodule

`default_nettype wire

>>> rtl/core/sic_tail.sv
// end of the chain: running total with saturation, overflow flag and the
// output register; depends on sic_pkg and sic_out_if
`default_nettype none

module sic_tail
    import sic_pkg::*;
#(
    parameter int HIT_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_sic_tok         i_tok,
    input  wire logic [HIT_W-1:0] i_hits,
    output logic                  o_adv,
    sic_out_if.source             o_out
);

    logic [TOTAL_W-1:0] r_total;
    logic               r_ovf;
    logic               r_out_vld;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_eos;
    logic               r_out_ovf;

    logic [TOTAL_W-1:0] n_total;
    logic               n_ovf;
    logic [SUM_W-1:0]   sum;

    assign o_adv = !r_out_vld || o_out.ready;

    always_comb begin
        sum = {1'b0, r_total} + {{(SUM_W-HIT_W){1'b0}}, i_hits};
        if (!i_tok.stored) begin
            // no free cell was found: sequence ran past capacity
            n_total = TOTAL_MAX;
            n_ovf   = 1'b1;
        end else begin
            n_ovf   = r_ovf;
            n_total = (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= i_tok.vld;
            if (i_tok.vld) begin
                r_out_total <= n_total;
                r_out_eos   <= i_tok.last;
                r_out_ovf   <= n_ovf;
                if (i_tok.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.running_total   = r_out_total;
    assign o_out.end_of_sequence = r_out_eos;
    assign o_out.overflow        = r_out_ovf;

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.running_total == TOTAL_MAX)
        else $error("overflow beat without saturated total");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_tok.vld && i_tok.last |=> r_total == '0 && !r_ovf)
        else $error("sequence state not cleared after closing item");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_tok.vld && !i_tok.stored && !i_tok.last |=> r_ovf)
        else $error("dropped item did not raise overflow");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && i_tok.vld && r_ovf && !i_tok.last |=> r_ovf && r_total == TOTAL_MAX)
        else $error("overflow lost inside a sequence");

endmodule

`default_nettype wire
